>>> hw/rtl/pcode_stack_machine_step_core_assert.svh
// Assertion macros shared by the p-code step core
`ifndef PCODE_STACK_MACHINE_STEP_CORE_ASSERT_SVH
`define PCODE_STACK_MACHINE_STEP_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define PCODE_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pcode step core: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define PCODE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pcode step core: next-cycle check failed");

`endif

>>> hw/rtl/pcode_pkg.sv
// Types, codes and helpers for the p-code step core
`timescale 1ns / 1ps
`default_nettype none
package pcode_pkg;
   localparam int unsigned DATA_W     = 32;
   localparam int unsigned ADDR_W     = 12;
   localparam int unsigned STACK_SIZE = 4096;
   localparam int unsigned PC_W       = 11;
   localparam int unsigned TOP_W      = 13;
   localparam int unsigned WRK_W      = 14;
   localparam int unsigned DIV_CNT_W  = 5;

   typedef logic [DATA_W-1:0]        word_type;
   typedef logic signed [WRK_W-1:0]  wrk_type;

   typedef struct packed {
      logic     start;
      word_type dividend;
      word_type divisor;
   } div_req_type;

   // opcodes
   localparam logic [2:0] FN_LIT = 3'd0;
   localparam logic [2:0] FN_OPR = 3'd1;
   localparam logic [2:0] FN_LOD = 3'd2;
   localparam logic [2:0] FN_STO = 3'd3;
   localparam logic [2:0] FN_CAL = 3'd4;
   localparam logic [2:0] FN_INT = 3'd5;
   localparam logic [2:0] FN_JMP = 3'd6;
   localparam logic [2:0] FN_JPC = 3'd7;

   // operator codes for OPR
   localparam logic [PC_W-1:0] OP_RET = 11'd0;
   localparam logic [PC_W-1:0] OP_NEG = 11'd1;
   localparam logic [PC_W-1:0] OP_ADD = 11'd2;
   localparam logic [PC_W-1:0] OP_SUB = 11'd3;
   localparam logic [PC_W-1:0] OP_MUL = 11'd4;
   localparam logic [PC_W-1:0] OP_DIV = 11'd5;
   localparam logic [PC_W-1:0] OP_ODD = 11'd6;
   localparam logic [PC_W-1:0] OP_EQL = 11'd8;
   localparam logic [PC_W-1:0] OP_NEQ = 11'd9;
   localparam logic [PC_W-1:0] OP_LSS = 11'd10;
   localparam logic [PC_W-1:0] OP_GEQ = 11'd11;
   localparam logic [PC_W-1:0] OP_GTR = 11'd12;
   localparam logic [PC_W-1:0] OP_LEQ = 11'd13;

   // fault codes
   localparam logic [1:0] FLT_NONE  = 2'd0;
   localparam logic [1:0] FLT_DIV   = 2'd1;
   localparam logic [1:0] FLT_RANGE = 2'd2;

   function automatic logic in_stack_wrk(input wrk_type v);
      return v[WRK_W-1:ADDR_W] == '0;
   endfunction

   function automatic logic in_stack_word(input word_type v);
      return v[DATA_W-1:ADDR_W] == '0;
   endfunction
endpackage
`default_nettype wire

>>> hw/rtl/pcode_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none
module pcode_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

>>> hw/rtl/pcode_alu.sv
// Combinational OPR arithmetic, logic and compare unit (no division)
`timescale 1ns / 1ps
`default_nettype none
module pcode_alu (
   input  wire logic [pcode_pkg::PC_W-1:0] op,
   input  wire pcode_pkg::word_type        x,
   input  wire pcode_pkg::word_type        y,
   output pcode_pkg::word_type             result
);
   pcode_pkg::word_type one;
   assign one = pcode_pkg::word_type'(1);

   always_comb begin
      case (op)
         pcode_pkg::OP_NEG: result = '0 - y;
         pcode_pkg::OP_ODD: result = y & one;
         pcode_pkg::OP_ADD: result = x + y;
         pcode_pkg::OP_SUB: result = x - y;
         pcode_pkg::OP_MUL: result = x * y;
         pcode_pkg::OP_EQL: result = (x == y) ? one : '0;
         pcode_pkg::OP_NEQ: result = (x != y) ? one : '0;
         pcode_pkg::OP_LSS: result = ($signed(x) <  $signed(y)) ? one : '0;
         pcode_pkg::OP_GEQ: result = ($signed(x) >= $signed(y)) ? one : '0;
         pcode_pkg::OP_GTR: result = ($signed(x) >  $signed(y)) ? one : '0;
         pcode_pkg::OP_LEQ: result = ($signed(x) <= $signed(y)) ? one : '0;
         default:           result = '0;
      endcase
   end
endmodule
`default_nettype wire

>>> hw/rtl/pcode_div.sv
// Unsigned restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module pcode_div (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire pcode_pkg::div_req_type div_req,
   output logic                        done,
   output pcode_pkg::word_type         quotient
);
   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [pcode_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   pcode_pkg::word_type               rem_ff, rem_in;
   pcode_pkg::word_type               quo_ff, quo_in;
   pcode_pkg::word_type               dvs_ff, dvs_in;
   logic [pcode_pkg::DATA_W:0]        trial;

   assign trial = {rem_ff, quo_ff[pcode_pkg::DATA_W-1]} - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (!trial[pcode_pkg::DATA_W]) begin
            rem_in = trial[pcode_pkg::DATA_W-1:0];
            quo_in = {quo_ff[pcode_pkg::DATA_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[pcode_pkg::DATA_W-2:0], quo_ff[pcode_pkg::DATA_W-1]};
            quo_in = {quo_ff[pcode_pkg::DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == '1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

>>> hw/rtl/pcode_stack_machine_step_core.sv
// Top level: executes one p-code instruction per request transfer
// Usage:
//   req channel: one instruction (func, level, operand) per transfer, fetched
//   at the next_pc of the previous response. One instruction is in flight at
//   a time; req_ready is high only while the core is idle.
//   rsp channel: one response per instruction with next pc, stack top value
//   and index, halt and fault flags.
// Sequence: decode, a static link walk for LOD, STO and CAL, operand reads
//   where the code needs them, execute, a divider wait for DIV and the two
//   extra frame writes for CAL, then a top-of-stack read and the response.
//   Range faults end early. A new request is taken only once the core is
//   back in idle after the response.
// Reset: pc 0, base 0, stack top -1; stack slots 1 to 3 read as zero until
//   written. No clearing pass is needed.
// Stall: a response waits in its output register while rsp_ready is low;
//   the next request can be taken but its result holds until the register
//   frees up.
`timescale 1ns / 1ps
`default_nettype none
`include "pcode_stack_machine_step_core_assert.svh"
module pcode_stack_machine_step_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [2:0]           req_func,
   input  wire logic [1:0]           req_level,
   input  wire logic [10:0]          req_operand,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [10:0]               rsp_next_pc,
   output logic signed [31:0]        rsp_top_value,
   output logic signed [12:0]        rsp_top_index,
   output logic                      rsp_halted,
   output logic [1:0]                rsp_fault
);
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_WALK   = 4'd2;
   localparam logic [3:0] S_WALKD  = 4'd3;
   localparam logic [3:0] S_PLAN   = 4'd4;
   localparam logic [3:0] S_RDX    = 4'd5;
   localparam logic [3:0] S_RDY    = 4'd6;
   localparam logic [3:0] S_EXEC   = 4'd7;
   localparam logic [3:0] S_DIVW   = 4'd8;
   localparam logic [3:0] S_CAL2   = 4'd9;
   localparam logic [3:0] S_CAL3   = 4'd10;
   localparam logic [3:0] S_TOPRD  = 4'd11;
   localparam logic [3:0] S_TOPD   = 4'd12;
   localparam logic [3:0] S_FIN    = 4'd13;

   localparam int unsigned AW = pcode_pkg::ADDR_W;
   localparam int unsigned PW = pcode_pkg::PC_W;

   logic [3:0]                 state_ff, state_in;
   logic [PW-1:0]              pc_ff, pc_in;
   logic [AW-1:0]              base_ff, base_in;
   logic signed [12:0]         top_ff, top_in;
   logic [2:0]                 fn_ff, fn_in;
   logic [1:0]                 lv_ff, lv_in;
   logic [PW-1:0]              opd_ff, opd_in;
   logic [PW-1:0]              np_ff, np_in;
   pcode_pkg::wrk_type         nt_ff, nt_in;
   logic [AW-1:0]              nb_ff, nb_in;
   logic [AW-1:0]              lbase_ff, lbase_in;
   pcode_pkg::word_type        lnk_ff, lnk_in;
   pcode_pkg::word_type        x_ff, x_in;
   pcode_pkg::word_type        y_ff, y_in;
   logic [AW-1:0]              ry_ff, ry_in;
   logic [1:0]                 flt_ff, flt_in;
   pcode_pkg::word_type        tv_ff, tv_in;
   logic                       neg_ff, neg_in;
   logic [3:1]                 vld_ff, vld_in;
   logic                       rdz_ff, rdz_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0]              rsp_pc_ff, rsp_pc_in;
   pcode_pkg::word_type        rsp_tv_ff, rsp_tv_in;
   logic signed [12:0]         rsp_ti_ff, rsp_ti_in;
   logic [1:0]                 rsp_flt_ff, rsp_flt_in;

   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   pcode_pkg::word_type        wr_data;
   logic [AW-1:0]              rd_addr;
   pcode_pkg::word_type        ram_q;
   pcode_pkg::word_type        rdata;
   pcode_pkg::word_type        alu_res;
   pcode_pkg::div_req_type     div_req;
   logic                       div_done;
   pcode_pkg::word_type        div_q;

   pcode_pkg::wrk_type t_w, b_w, a_w, lb_w, addr_w, t_p1, t_p3, t_m1, t_pa, b_p1, b_p2;
   logic is_binop;

   assign t_w    = {top_ff[12], top_ff};
   assign b_w    = {2'b00, base_ff};
   assign a_w    = {3'b000, opd_ff};
   assign lb_w   = {2'b00, lbase_ff};
   assign addr_w = lb_w + a_w;
   assign t_p1   = t_w + 14'sd1;
   assign t_p3   = t_w + 14'sd3;
   assign t_m1   = t_w - 14'sd1;
   assign t_pa   = t_w + a_w;
   assign b_p1   = b_w + 14'sd1;
   assign b_p2   = b_w + 14'sd2;

   assign is_binop = (opd_ff == pcode_pkg::OP_ADD) || (opd_ff == pcode_pkg::OP_SUB)
                  || (opd_ff == pcode_pkg::OP_MUL) || (opd_ff == pcode_pkg::OP_DIV)
                  || (opd_ff == pcode_pkg::OP_EQL) || (opd_ff == pcode_pkg::OP_NEQ)
                  || (opd_ff == pcode_pkg::OP_LSS) || (opd_ff == pcode_pkg::OP_GEQ)
                  || (opd_ff == pcode_pkg::OP_GTR) || (opd_ff == pcode_pkg::OP_LEQ);

   // slots 1 to 3 read as zero until their first write
   assign rdata = rdz_ff ? '0 : ram_q;

   pcode_ram #(
      .WIDTH(pcode_pkg::DATA_W),
      .DEPTH(pcode_pkg::STACK_SIZE)
   ) u_stack (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(ram_q)
   );

   pcode_alu u_alu (
      .op    (opd_ff),
      .x     (x_ff),
      .y     (y_ff),
      .result(alu_res)
   );

   pcode_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .done    (div_done),
      .quotient(div_q)
   );

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      base_in  = base_ff;
      top_in   = top_ff;
      fn_in    = fn_ff;
      lv_in    = lv_ff;
      opd_in   = opd_ff;
      np_in    = np_ff;
      nt_in    = nt_ff;
      nb_in    = nb_ff;
      lbase_in = lbase_ff;
      lnk_in   = lnk_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      ry_in    = ry_ff;
      flt_in   = flt_ff;
      tv_in    = tv_ff;
      neg_in   = neg_ff;
      wr_en    = 1'b0;
      wr_addr  = '0;
      wr_data  = '0;
      rd_addr  = '0;
      div_req.start    = 1'b0;
      div_req.dividend = x_ff[31] ? ('0 - x_ff) : x_ff;
      div_req.divisor  = y_ff[31] ? ('0 - y_ff) : y_ff;

      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_pc_in    = rsp_pc_ff;
      rsp_tv_in    = rsp_tv_ff;
      rsp_ti_in    = rsp_ti_ff;
      rsp_flt_in   = rsp_flt_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               fn_in    = req_func;
               lv_in    = req_level;
               opd_in   = req_operand;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            np_in  = pc_ff + 1'b1;
            nt_in  = t_w;
            nb_in  = base_ff;
            flt_in = pcode_pkg::FLT_NONE;
            tv_in  = '0;
            if ((fn_ff == pcode_pkg::FN_LOD) || (fn_ff == pcode_pkg::FN_STO)
                || (fn_ff == pcode_pkg::FN_CAL)) begin
               lnk_in   = {{(pcode_pkg::DATA_W-AW){1'b0}}, base_ff};
               state_in = S_WALK;
            end else begin
               state_in = S_PLAN;
            end
         end
         S_WALK: begin
            if (!pcode_pkg::in_stack_word(lnk_ff)) begin
               flt_in   = pcode_pkg::FLT_RANGE;
               state_in = S_FIN;
            end else if (lv_ff == '0) begin
               lbase_in = lnk_ff[AW-1:0];
               state_in = S_PLAN;
            end else begin
               rd_addr  = lnk_ff[AW-1:0];
               state_in = S_WALKD;
            end
         end
         S_WALKD: begin
            lnk_in   = rdata;
            lv_in    = lv_ff - 1'b1;
            state_in = S_WALK;
         end
         S_PLAN: begin
            state_in = S_TOPRD;
            case (fn_ff)
               pcode_pkg::FN_LIT: begin
                  if (!pcode_pkg::in_stack_wrk(t_p1)) begin
                     flt_in   = pcode_pkg::FLT_RANGE;
                     state_in = S_FIN;
                  end else begin
                     state_in = S_EXEC;
                  end
               end
               pcode_pkg::FN_OPR: begin
                  if (opd_ff == pcode_pkg::OP_RET) begin
                     if (!pcode_pkg::in_stack_wrk(b_p2)) begin
                        flt_in   = pcode_pkg::FLT_RANGE;
                        state_in = S_FIN;
                     end else begin
                        rd_addr  = b_p1[AW-1:0];
                        ry_in    = b_p2[AW-1:0];
                        state_in = S_RDX;
                     end
                  end else if ((opd_ff == pcode_pkg::OP_NEG)
                               || (opd_ff == pcode_pkg::OP_ODD)) begin
                     if (!pcode_pkg::in_stack_wrk(t_w)) begin
                        flt_in   = pcode_pkg::FLT_RANGE;
                        state_in = S_FIN;
                     end else begin
                        rd_addr  = t_w[AW-1:0];
                        state_in = S_RDY;
                     end
                  end else if (is_binop) begin
                     if ((t_w < 14'sd1) || !pcode_pkg::in_stack_wrk(t_w)) begin
                        flt_in   = pcode_pkg::FLT_RANGE;
                        state_in = S_FIN;
                     end else begin
                        rd_addr  = t_m1[AW-1:0];
                        ry_in    = t_w[AW-1:0];
                        state_in = S_RDX;
                     end
                  end
               end
               pcode_pkg::FN_LOD: begin
                  if (!pcode_pkg::in_stack_wrk(t_p1) || !pcode_pkg::in_stack_wrk(addr_w)) begin
                     flt_in   = pcode_pkg::FLT_RANGE;
                     state_in = S_FIN;
                  end else begin
                     rd_addr  = addr_w[AW-1:0];
                     state_in = S_RDY;
                  end
               end
               pcode_pkg::FN_STO: begin
                  if (!pcode_pkg::in_stack_wrk(t_w) || !pcode_pkg::in_stack_wrk(addr_w)) begin
                     flt_in   = pcode_pkg::FLT_RANGE;
                     state_in = S_FIN;
                  end else begin
                     rd_addr  = t_w[AW-1:0];
                     state_in = S_RDY;
                  end
               end
               pcode_pkg::FN_CAL: begin
                  if (!pcode_pkg::in_stack_wrk(t_p1) || !pcode_pkg::in_stack_wrk(t_p3)) begin
                     flt_in   = pcode_pkg::FLT_RANGE;
                     state_in = S_FIN;
                  end else begin
                     state_in = S_EXEC;
                  end
               end
               pcode_pkg::FN_INT: begin
                  if (t_pa > 14'sd4095) begin
                     flt_in   = pcode_pkg::FLT_RANGE;
                     state_in = S_FIN;
                  end else begin
                     nt_in = t_pa;
                  end
               end
               pcode_pkg::FN_JMP: begin
                  np_in = opd_ff;
               end
               pcode_pkg::FN_JPC: begin
                  if (!pcode_pkg::in_stack_wrk(t_w)) begin
                     flt_in   = pcode_pkg::FLT_RANGE;
                     state_in = S_FIN;
                  end else begin
                     rd_addr  = t_w[AW-1:0];
                     state_in = S_RDY;
                  end
               end
               default: state_in = S_TOPRD;
            endcase
         end
         S_RDX: begin
            x_in     = rdata;
            rd_addr  = ry_ff;
            state_in = S_RDY;
         end
         S_RDY: begin
            y_in     = rdata;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_TOPRD;
            case (fn_ff)
               pcode_pkg::FN_LIT: begin
                  wr_en   = 1'b1;
                  wr_addr = t_p1[AW-1:0];
                  wr_data = {{(pcode_pkg::DATA_W-PW){1'b0}}, opd_ff};
                  nt_in   = t_p1;
               end
               pcode_pkg::FN_OPR: begin
                  if (opd_ff == pcode_pkg::OP_RET) begin
                     if (!pcode_pkg::in_stack_word(x_ff)) begin
                        flt_in   = pcode_pkg::FLT_RANGE;
                        state_in = S_FIN;
                     end else begin
                        nt_in = b_w - 14'sd1;
                        nb_in = x_ff[AW-1:0];
                        np_in = y_ff[PW-1:0];
                     end
                  end else if ((opd_ff == pcode_pkg::OP_NEG)
                               || (opd_ff == pcode_pkg::OP_ODD)) begin
                     wr_en   = 1'b1;
                     wr_addr = t_w[AW-1:0];
                     wr_data = alu_res;
                  end else if (opd_ff == pcode_pkg::OP_DIV) begin
                     nt_in = t_m1;
                     if (y_ff == '0) begin
                        wr_en   = 1'b1;
                        wr_addr = t_m1[AW-1:0];
                        wr_data = '0;
                        flt_in  = pcode_pkg::FLT_DIV;
                     end else begin
                        div_req.start = 1'b1;
                        neg_in        = x_ff[31] ^ y_ff[31];
                        state_in      = S_DIVW;
                     end
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = t_m1[AW-1:0];
                     wr_data = alu_res;
                     nt_in   = t_m1;
                  end
               end
               pcode_pkg::FN_LOD: begin
                  wr_en   = 1'b1;
                  wr_addr = t_p1[AW-1:0];
                  wr_data = y_ff;
                  nt_in   = t_p1;
               end
               pcode_pkg::FN_STO: begin
                  wr_en   = 1'b1;
                  wr_addr = addr_w[AW-1:0];
                  wr_data = y_ff;
                  nt_in   = t_m1;
               end
               pcode_pkg::FN_CAL: begin
                  wr_en    = 1'b1;
                  wr_addr  = t_p1[AW-1:0];
                  wr_data  = {{(pcode_pkg::DATA_W-AW){1'b0}}, lbase_ff};
                  state_in = S_CAL2;
               end
               pcode_pkg::FN_JPC: begin
                  if (y_ff == pcode_pkg::word_type'(1)) begin
                     np_in = opd_ff;
                  end
                  nt_in = t_m1;
               end
               default: state_in = S_TOPRD;
            endcase
         end
         S_DIVW: begin
            if (div_done) begin
               wr_en    = 1'b1;
               wr_addr  = t_m1[AW-1:0];
               wr_data  = neg_ff ? ('0 - div_q) : div_q;
               state_in = S_TOPRD;
            end
         end
         S_CAL2: begin
            wr_en    = 1'b1;
            wr_addr  = t_p1[AW-1:0] + 1'b1;
            wr_data  = {{(pcode_pkg::DATA_W-AW){1'b0}}, base_ff};
            state_in = S_CAL3;
         end
         S_CAL3: begin
            wr_en    = 1'b1;
            wr_addr  = t_p3[AW-1:0];
            wr_data  = {{(pcode_pkg::DATA_W-PW){1'b0}}, np_ff};
            nb_in    = t_p1[AW-1:0];
            np_in    = opd_ff;
            state_in = S_TOPRD;
         end
         S_TOPRD: begin
            rd_addr  = nt_ff[AW-1:0];
            state_in = S_TOPD;
         end
         S_TOPD: begin
            if (!nt_ff[pcode_pkg::WRK_W-1] && (flt_ff == pcode_pkg::FLT_NONE)) begin
               tv_in = rdata;
            end
            state_in = S_FIN;
         end
         S_FIN: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_pc_in    = np_ff;
               rsp_flt_in   = flt_ff;
               rsp_tv_in    = tv_ff;
               pc_in        = np_ff;
               if (flt_ff != pcode_pkg::FLT_RANGE) begin
                  top_in    = nt_ff[12:0];
                  base_in   = nb_ff;
                  rsp_ti_in = nt_ff[12:0];
               end else begin
                  rsp_ti_in = top_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      vld_in = vld_ff;
      if (wr_en && (wr_addr[AW-1:2] == '0) && (wr_addr[1:0] != 2'd0)) begin
         vld_in[wr_addr[1:0]] = 1'b1;
      end
      rdz_in = (rd_addr[AW-1:2] == '0) && (rd_addr[1:0] != 2'd0) && !vld_ff[rd_addr[1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= '0;
         base_ff      <= '0;
         top_ff       <= -13'sd1;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         base_ff      <= base_in;
         top_ff       <= top_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fn_ff      <= fn_in;
      lv_ff      <= lv_in;
      opd_ff     <= opd_in;
      np_ff      <= np_in;
      nt_ff      <= nt_in;
      nb_ff      <= nb_in;
      lbase_ff   <= lbase_in;
      lnk_ff     <= lnk_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      ry_ff      <= ry_in;
      flt_ff     <= flt_in;
      tv_ff      <= tv_in;
      neg_ff     <= neg_in;
      rdz_ff     <= rdz_in;
      rsp_pc_ff  <= rsp_pc_in;
      rsp_tv_ff  <= rsp_tv_in;
      rsp_ti_ff  <= rsp_ti_in;
      rsp_flt_ff <= rsp_flt_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_next_pc   = rsp_pc_ff;
   assign rsp_top_value = rsp_tv_ff;
   assign rsp_top_index = rsp_ti_ff;
   assign rsp_halted    = (rsp_pc_ff == '0);
   assign rsp_fault     = rsp_flt_ff;

   `PCODE_ASSERT_NOW(a_fault_zero_top, rsp_valid && (rsp_fault != pcode_pkg::FLT_NONE), rsp_top_value == '0)
   `PCODE_ASSERT_NOW(a_halt_matches_pc, rsp_valid, rsp_halted == (rsp_next_pc == '0))
   `PCODE_ASSERT_NEXT(a_accept_starts, req_valid && req_ready, state_ff == S_DECODE)
endmodule
`default_nettype wire
